FILE: src/lzss_pkg.sv
`timescale 1ns / 1ps

package lzss_pkg;

    localparam int POS_WIDTH = 12;
    localparam int POS_MAX   = (1 << POS_WIDTH) - 1;
    localparam int CNT_WIDTH = 5;

    localparam logic [8:0]           FLAG_MARKER = 9'h100;
    localparam logic [CNT_WIDTH-1:0] LEN_BIAS    = 5'd3;

    typedef enum logic [1:0] {
        PH_TOKEN   = 2'd0,
        PH_FLAGGED = 2'd1,
        PH_REF     = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOAD = 2'd1,
        ST_EMIT = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic acc_copy;
        logic copy_last;
    } dp_status_t;

endpackage

FILE: src/lzss_ram.sv
`timescale 1ns / 1ps

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lzss_ctrl.sv
`timescale 1ns / 1ps

module lzss_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lzss_pkg::dp_status_t   status,
    output lzss_pkg::ctrl_cmd_t    cmd
);

    import lzss_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && status.out_free && status.acc_copy) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free && status.copy_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = status.out_free;
                cmd.accept = s_tvalid && status.out_free;
            end
            ST_LOAD: begin
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/lzss_dpath.sv
`timescale 1ns / 1ps

module lzss_dpath #(
    parameter int RING_SIZE     = 4096,
    parameter int LONGEST_MATCH = 18
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lzss_pkg::ctrl_cmd_t   cmd,
    output lzss_pkg::dp_status_t  status,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_data
);

    import lzss_pkg::*;

    localparam int AW        = $clog2(RING_SIZE);
    localparam int FW        = AW + 1;
    localparam int MOD_STEPS = $clog2((POS_MAX + 1) / RING_SIZE) + 1;
    localparam logic [AW-1:0] START_POS = AW'((RING_SIZE - LONGEST_MATCH) % RING_SIZE);
    localparam logic [AW-1:0] LAST_POS  = AW'(RING_SIZE - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(RING_SIZE);

    logic [31:0]          out_len_reg, out_len_next;
    logic [31:0]          rem_reg, rem_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [8:0]           flag_reg, flag_next;
    phase_t               phase_reg, phase_next;
    logic [7:0]           low_reg, low_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_done_reg, out_done_next;
    logic                 hit_reg, hit_next;
    logic [7:0]           byp_reg, byp_next;
    logic                 rvalid_reg, rvalid_next;

    logic          restart;
    phase_t        phase_e;
    logic [8:0]    flag_e;
    logic [8:0]    flag_sh;
    logic [31:0]   rem_e;
    logic [AW-1:0] wp_e;
    logic [FW-1:0] fill_e;
    logic [AW-1:0] pos_mod;
    logic [7:0]    copy_byte;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] rd_off;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        ring_inc = (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [FW-1:0] fill_inc(input logic [FW-1:0] f);
        fill_inc = (f == FILL_FULL) ? f : f + 1'b1;
    endfunction

    assign restart = s_tuser;
    assign phase_e = restart ? PH_TOKEN : phase_reg;
    assign flag_e  = restart ? '0 : flag_reg;
    assign flag_sh = flag_e >> 1;
    assign rem_e   = restart ? out_len_reg : rem_reg;
    assign wp_e    = restart ? START_POS : wp_reg;
    assign fill_e  = restart ? '0 : fill_reg;

    // reference position reduced into the ring
    always_comb begin
        logic [POS_WIDTH-1:0] pos_v;
        pos_v = {s_tdata[7:4], low_reg};
        for (int j = MOD_STEPS - 1; j >= 0; j--) begin
            if ((RING_SIZE << j) <= POS_MAX && int'(pos_v) >= (RING_SIZE << j)) begin
                pos_v = pos_v - POS_WIDTH'(RING_SIZE << j);
            end
        end
        pos_mod = AW'(pos_v);
    end

    assign copy_byte = hit_reg ? byp_reg : (rvalid_reg ? ram_rdata : 8'd0);

    // distance of the read position from the stream start, for the fill check
    always_comb begin
        if (ram_raddr >= START_POS) begin
            rd_off = ram_raddr - START_POS;
        end else begin
            rd_off = AW'({1'b0, ram_raddr} + FW'(RING_SIZE) - {1'b0, START_POS});
        end
    end

    assign ram_raddr = cmd.emit ? ring_inc(rd_ptr_reg) : rd_ptr_reg;

    always_comb begin
        logic tok_take;
        logic tok_bit;
        out_len_next   = out_len_reg;
        rem_next       = rem_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        flag_next      = flag_reg;
        phase_next     = phase_reg;
        low_next       = low_reg;
        rd_ptr_next    = cmd.emit ? ring_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = copy_byte;
        tok_take       = 1'b0;
        tok_bit        = 1'b0;

        if (cfg_we) begin
            out_len_next = cfg_data;
            rem_next     = cfg_data;
        end

        if (cmd.accept) begin
            wp_next    = wp_e;
            fill_next  = fill_e;
            flag_next  = flag_e;
            phase_next = phase_e;
            rem_next   = rem_e;
            if (restart) begin
                low_next = '0;
            end
            if (rem_e != '0) begin
                unique case (phase_e)
                    PH_REF: begin
                        phase_next  = PH_TOKEN;
                        rd_ptr_next = pos_mod;
                        cnt_next    = {1'b0, s_tdata[3:0]} + LEN_BIAS;
                    end
                    PH_FLAGGED: begin
                        tok_take = 1'b1;
                        tok_bit  = flag_e[0];
                    end
                    default: begin
                        if (flag_sh <= 9'd1) begin
                            flag_next  = FLAG_MARKER | {1'b0, s_tdata};
                            phase_next = PH_FLAGGED;
                        end else begin
                            flag_next = flag_sh;
                            tok_take  = 1'b1;
                            tok_bit   = flag_sh[0];
                        end
                    end
                endcase
            end
            if (tok_take) begin
                if (tok_bit) begin
                    phase_next     = PH_TOKEN;
                    ram_we         = 1'b1;
                    ram_waddr      = wp_e;
                    ram_wdata      = s_tdata;
                    wp_next        = ring_inc(wp_e);
                    fill_next      = fill_inc(fill_e);
                    rem_next       = rem_e - 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = s_tdata;
                    out_last_next  = 1'b1;
                    out_done_next  = (rem_e == 32'd1);
                end else begin
                    low_next   = s_tdata;
                    phase_next = PH_REF;
                end
            end
        end

        if (cmd.emit) begin
            ram_we         = 1'b1;
            ram_waddr      = wp_reg;
            ram_wdata      = copy_byte;
            wp_next        = ring_inc(wp_reg);
            fill_next      = fill_inc(fill_reg);
            rem_next       = rem_reg - 1'b1;
            cnt_next       = cnt_reg - 1'b1;
            out_valid_next = 1'b1;
            out_data_next  = copy_byte;
            out_last_next  = status.copy_last;
            out_done_next  = (rem_reg == 32'd1);
        end
    end

    assign hit_next    = ram_we && (ram_waddr == ram_raddr);
    assign byp_next    = ram_wdata;
    assign rvalid_next = ({1'b0, rd_off} < fill_reg);

    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.acc_copy  = (rem_e != '0) && (phase_e == PH_REF);
    assign status.copy_last = (cnt_reg == CNT_WIDTH'(1)) || (rem_reg == 32'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_len_reg   <= '0;
            rem_reg       <= '0;
            wp_reg        <= START_POS;
            fill_reg      <= '0;
            flag_reg      <= '0;
            phase_reg     <= PH_TOKEN;
            low_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_len_reg   <= out_len_next;
            rem_reg       <= rem_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            flag_reg      <= flag_next;
            phase_reg     <= phase_next;
            low_reg       <= low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
        hit_reg      <= hit_next;
        byp_reg      <= byp_next;
        rvalid_reg   <= rvalid_next;
    end

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

FILE: src/lzss_stream_decoder_unit.sv
`timescale 1ns / 1ps

// lzss stream decoder: one compressed byte per input item, decoded bytes out
// s_ channel: compressed bytes; s_tuser restarts the stream with that item
// m_ channel: one decoded byte per item; m_tlast marks the final byte of the
//   input item that caused it, m_tuser marks the byte that completes the stream
// cfg channel: write of the expected output length (also rearms the stream);
//   cfg_ready is always high, write only while no item is in flight
// a flag byte or a reference low byte: accepted, no output
// a literal: accepted, visible on m_ the next cycle
// a reference of n bytes: a load state, then one byte per cycle while m_ is free,
//   from the 4096-byte history ring (registered read port), then next item taken
// restart needs no clearing pass: a fill count marks written ring entries
// and unwritten ones read as zero
// reset: output length 0, stream empty; items are dropped until a length is
//   written and, after the length is reached, until the next restart
// a stalled m_ side holds the output register and pauses decoding; s_tready
//   follows the output register being free while no copy is running
module lzss_stream_decoder_unit #(
    parameter int RING_SIZE     = 4096,
    parameter int LONGEST_MATCH = 18
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // first_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,
    output logic        m_tuser,   // stream_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    import lzss_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lzss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzss_dpath #(
        .RING_SIZE     (RING_SIZE),
        .LONGEST_MATCH (LONGEST_MATCH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data)
    );

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while output register is blocked");

    a_copy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.acc_copy) |=> !s_tready)
        else $error("input accepted during a copy");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("stream end not on the last byte of an item");

    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !cmd.accept)
        else $error("copy byte and input item in the same cycle");

endmodule

FILE: tb/sv/lzss_stream_decoder_unit_test.sv
`timescale 1ns / 1ps

module lzss_stream_decoder_unit_test;

    import lzss_pkg::*;

    localparam int RING_DEPTH  = POS_MAX + 1;
    localparam int LONGEST_RUN = 18;

    typedef struct packed {
        logic [7:0] code;
        logic       restart;
    } code_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       done;
    } decoded_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'h0;

    code_item_t  code_items[$];
    decoded_t    decoded_bytes[$];
    int unsigned queued_items = 0;
    int unsigned mismatches = 0;
    bit          idle_on = 1'b1;

    // handshake history and wait counters
    logic        s_took = 1'b0;
    logic        m_took = 1'b0;
    int unsigned s_hold = 0;
    int unsigned m_stall = 0;

    // decoder state
    logic [7:0]           history [RING_DEPTH];
    logic [POS_WIDTH-1:0] write_pos;
    logic [8:0]           flag_bits;
    phase_t               phase;
    logic [7:0]           ref_low;
    logic [31:0]          bytes_left;
    logic [31:0]          length_reg;

    lzss_stream_decoder_unit #(
        .RING_SIZE    (RING_DEPTH),
        .LONGEST_MATCH(LONGEST_RUN)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic void restart_history();
        int i;
        for (i = 0; i < RING_DEPTH; i++) history[i] = 8'h00;
        write_pos  = POS_WIDTH'(RING_DEPTH - LONGEST_RUN);
        flag_bits  = '0;
        phase      = PH_TOKEN;
        ref_low    = '0;
        bytes_left = length_reg;
    endfunction

    function automatic void set_length(logic [31:0] value);
        length_reg = value;
        bytes_left = value;
    endfunction

    function automatic void emit_decoded(logic [7:0] value);
        decoded_t d;
        history[write_pos] = value;
        write_pos  = write_pos + 1'b1;
        bytes_left = bytes_left - 1;
        d.value = value;
        d.last  = 1'b0;
        d.done  = (bytes_left == 0);
        decoded_bytes.push_back(d);
    endfunction

    function automatic void take_token(logic [7:0] b);
        if (flag_bits[0]) begin
            emit_decoded(b);
            phase = PH_TOKEN;
        end else begin
            ref_low = b;
            phase   = PH_REF;
        end
    endfunction

    function automatic void decode_code_byte(logic [7:0] b, logic restart);
        logic [POS_WIDTH-1:0] src;
        int unsigned run_len;
        int unsigned k;
        int unsigned before_count;
        decoded_t tail;
        if (restart) restart_history();
        if (bytes_left == 0) return;
        before_count = decoded_bytes.size();
        case (phase)
            PH_REF: begin
                src     = {b[7:4], ref_low};
                run_len = 32'({1'b0, b[3:0]} + LEN_BIAS);
                for (k = 0; k < run_len && bytes_left != 0; k++)
                    emit_decoded(history[POS_WIDTH'(src + k)]);
                phase = PH_TOKEN;
            end
            PH_FLAGGED: take_token(b);
            default: begin
                flag_bits = flag_bits >> 1;
                if (flag_bits <= 9'd1) begin
                    flag_bits = FLAG_MARKER | {1'b0, b};
                    phase     = PH_FLAGGED;
                end else begin
                    take_token(b);
                end
            end
        endcase
        if (decoded_bytes.size() > before_count) begin
            tail = decoded_bytes.pop_back();
            tail.last = 1'b1;
            decoded_bytes.push_back(tail);
        end
    endfunction

    function automatic int unsigned draw_wait();
        if (!idle_on || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic push_code(input logic [7:0] b, input logic restart);
        code_item_t item;
        item.code    = b;
        item.restart = restart;
        code_items.push_back(item);
        queued_items++;
    endtask

    // flag bytes, literals, refs (most near recent output), a stray tail if broken
    task automatic gen_stream(input int unsigned tokens, input bit with_restart,
                              input bit broken);
        int unsigned produced;
        int unsigned t;
        int unsigned i;
        logic [7:0] flags;
        logic [3:0] nib;
        logic [POS_WIDTH-1:0] src;
        bit first;
        produced = 0;
        first = with_restart;
        for (t = 0; t < tokens; t += 8) begin
            flags = 8'($urandom_range(0, 255));
            push_code(flags, first);
            first = 1'b0;
            for (i = 0; i < 8 && t + i < tokens; i++) begin
                if (flags[i]) begin
                    push_code(8'($urandom_range(0, 255)), 1'b0);
                    produced++;
                end else begin
                    nib = 4'($urandom_range(0, 15));
                    if ($urandom_range(0, 3) == 0)
                        src = POS_WIDTH'($urandom);
                    else
                        src = POS_WIDTH'(RING_DEPTH - LONGEST_RUN + produced
                                         - $urandom_range(1, 48));
                    push_code(src[7:0], 1'b0);
                    push_code({src[11:8], nib}, 1'b0);
                    produced += nib + LEN_BIAS;
                end
            end
        end
        if (broken) push_code(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic write_length(input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (code_items.size() != 0 || s_tvalid || decoded_bytes.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    always @(negedge aclk) begin : code_driver
        int unsigned hold;
        code_item_t next_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_hold   <= 0;
        end else if (!(s_tvalid && !s_took)) begin
            hold = s_tvalid ? draw_wait() : s_hold;
            if (hold == 0 && code_items.size() != 0) begin
                next_item = code_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.code;
                s_tuser  <= next_item.restart;
                s_hold   <= 0;
            end else begin
                s_tvalid <= 1'b0;
                s_hold   <= (hold == 0) ? 0 : hold - 1;
            end
        end
    end

    always @(negedge aclk) begin : byte_sink
        int unsigned stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_stall  <= 0;
        end else begin
            stall = m_took ? draw_wait() : m_stall;
            m_tready <= (stall == 0);
            m_stall  <= (stall == 0) ? 0 : stall - 1;
        end
    end

    always @(posedge aclk) begin : monitor
        decoded_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
            m_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            m_took <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                if (decoded_bytes.size() == 0) begin
                    report_mismatch("unexpected item", 32'(m_tdata), 32'd0);
                end else begin
                    want = decoded_bytes.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("out_byte", 32'(m_tdata), 32'(want.value));
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_run", 32'(m_tlast), 32'(want.last));
                    if (m_tuser !== want.done)
                        report_mismatch("stream_done", 32'(m_tuser), 32'(want.done));
                end
            end
            if (cfg_valid && cfg_ready) set_length(cfg_data);
            if (s_tvalid && s_tready) decode_code_byte(s_tdata, s_tuser);
        end
    end

    initial begin : stimulus
        int unsigned random_items;
        int unsigned queued_before;
        logic [31:0] new_length;
        int unsigned b;
        random_items = 0;
        length_reg = '0;
        restart_history();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero length after reset: nothing comes out
        push_code(8'hFF, 1'b1);
        push_code(8'h12, 1'b0);
        wait_idle();

        // literals at both extremes, overlapping copy, copy across the ring end,
        // copy cut short at the length, then ignored bytes after the end
        write_length(32'd40);
        push_code(8'h43, 1'b1);
        push_code(8'h00, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'hEE, 1'b0);
        push_code(8'hF0, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'hEE, 1'b0);
        push_code(8'hF5, 1'b0);
        push_code(8'h10, 1'b0);
        push_code(8'h0F, 1'b0);
        push_code(8'h5A, 1'b0);
        push_code(8'h22, 1'b0);
        push_code(8'h33, 1'b0);
        wait_idle();

        // restart reloads the length; restart in the middle of a reference
        push_code(8'hFF, 1'b1);
        for (b = 0; b < 8; b++) push_code(8'h01 << b, 1'b0);
        push_code(8'h00, 1'b0);
        push_code(8'h34, 1'b0);
        push_code(8'hFF, 1'b1);
        push_code(8'hA5, 1'b0);
        wait_idle();

        while (random_items < 260) begin
            case ($urandom_range(0, 9))
                0:       new_length = 32'd1;
                1:       new_length = 32'hFFFF_FFFF;
                2:       new_length = 32'd0;
                default: new_length = $urandom_range(16, 400);
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            write_length(new_length);
            queued_before = queued_items;
            case ($urandom_range(0, 7))
                0: repeat ($urandom_range(4, 20))
                       push_code(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                1: gen_stream($urandom_range(2, 30), 1'b1, 1'b1);
                2: gen_stream($urandom_range(1, 30), 1'b0, 1'b0);
                default: gen_stream($urandom_range(1, 40), 1'b1, 1'b0);
            endcase
            if (new_length != 0) random_items += queued_items - queued_before;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("lzss_stream_decoder_unit regression: pass");
        end else begin
            $display("lzss_stream_decoder_unit regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("lzss_stream_decoder_unit regression: fail");
        $finish;
    end

endmodule
